>>> rtl/core/tpic_pkg.sv
// ----------------------------------------------------------------------------
// tpic_pkg
// Shared widths, codes and stage types of the triangular pair index codec.
// ----------------------------------------------------------------------------
package tpic_pkg;

    localparam int ORD_BITS = 31;
    localparam int IN_ORD_W = 32;
    localparam int IN_IDX_W = 64;
    localparam int IDX_W    = 2 * ORD_BITS - 1;
    localparam int ROOT_W   = ORD_BITS + 1;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int PROD_W   = 2 * ORD_BITS;

    localparam logic [IN_IDX_W-1:0] ORD_MAX  = (IN_IDX_W'(1) << ORD_BITS) - IN_IDX_W'(1);
    localparam logic [IN_IDX_W-1:0] TRI_MAX  = (ORD_MAX * (ORD_MAX + IN_IDX_W'(1))) >> 1;
    localparam logic [RAD_W-1:0]    RAD_BIAS = RAD_W'(7);

    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_ENCODE = 1'b1
    } tpic_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NEG   = 2'd1,
        ST_ORDER = 2'd2,
        ST_RANGE = 2'd3
    } tpic_status_t;

    typedef struct packed {
        tpic_op_t              op;
        tpic_status_t          st;
        logic [IDX_W-1:0]      arg;
        logic [ORD_BITS-1:0]   upe;
        logic [RAD_W-1:0]      rad;
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
    } tpic_root_t;

    typedef struct packed {
        tpic_op_t              op;
        tpic_status_t          st;
        logic [IDX_W-1:0]      arg;
        logic [ORD_BITS-1:0]   u;
        logic [ORD_BITS-1:0]   um1;
    } tpic_post_t;

    typedef struct packed {
        tpic_op_t              op;
        tpic_status_t          st;
        logic [IDX_W-1:0]      arg;
        logic [ORD_BITS-1:0]   u;
        logic [PROD_W-1:0]     prod;
    } tpic_prod_t;

    typedef struct packed {
        logic [IDX_W-1:0]      index;
        logic [ORD_BITS-1:0]   lower;
        logic [ORD_BITS-1:0]   upper;
        tpic_status_t          status;
    } tpic_res_t;

endpackage

>>> rtl/core/tpic_root_step.sv
// ----------------------------------------------------------------------------
// tpic_root_step
// One registered step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module tpic_root_step (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  tpic_pkg::tpic_root_t  in_data,
    output logic                  out_valid,
    output tpic_pkg::tpic_root_t  out_data
);

    logic                        valid_reg;
    tpic_pkg::tpic_root_t        data_reg;
    tpic_pkg::tpic_root_t        data_next;
    logic [tpic_pkg::REM_W-1:0]  rem_shift;
    logic [tpic_pkg::REM_W-1:0]  trial;

    always_comb begin
        rem_shift = {in_data.rem[tpic_pkg::REM_W-3:0], in_data.rad[tpic_pkg::RAD_W-1 -: 2]};
        trial     = {in_data.root, 2'b01};
        data_next     = in_data;
        data_next.rad = in_data.rad << 2;
        if (rem_shift >= trial) begin
            data_next.rem  = rem_shift - trial;
            data_next.root = {in_data.root[tpic_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = rem_shift;
            data_next.root = {in_data.root[tpic_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/triangular_pair_index_codec_unit.sv
// ----------------------------------------------------------------------------
// triangular_pair_index_codec_unit
// Converts between an ordered ordinal pair and its lower-triangular index.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_valid/s_ready. s_opcode selects decode of
//   s_pair_index or encode of s_lower_ordinal/s_upper_ordinal. Each beat gives
//   exactly one result beat on m_valid/m_ready, in order: m_index_out for an
//   encode, m_lower_out/m_upper_out for a decode, m_status for both.
//   A taken beat passes through the capture register, the square root
//   pipeline of ORD_BITS + 1 steps, then the root fixup, multiply and
//   output stages.
//   Throughput: one beat per cycle while the skid buffer is empty and m_ready is high.
//   Stall: the output register is backed by a one-beat skid buffer. A result
//   that is not taken moves the next one into the skid buffer; only when that
//   is full does s_ready fall and the whole pipeline hold.
//   Reset: aresetn (synchronous, active low) drops every beat in flight;
//   s_ready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module triangular_pair_index_codec_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic signed [tpic_pkg::IN_IDX_W-1:0] s_pair_index,
    input  logic signed [tpic_pkg::IN_ORD_W-1:0] s_lower_ordinal,
    input  logic signed [tpic_pkg::IN_ORD_W-1:0] s_upper_ordinal,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tpic_pkg::IDX_W-1:0]          m_index_out,
    output logic [tpic_pkg::ORD_BITS-1:0]       m_lower_out,
    output logic [tpic_pkg::ORD_BITS-1:0]       m_upper_out,
    output logic [1:0]                          m_status
);

    logic                     en;
    logic                     s0_valid_reg;
    tpic_pkg::tpic_root_t     s0_data_reg;
    tpic_pkg::tpic_root_t     s0_data_next;
    logic                     root_valid [tpic_pkg::ROOT_W+1];
    tpic_pkg::tpic_root_t     root_data  [tpic_pkg::ROOT_W+1];
    logic                     u_valid_reg;
    tpic_pkg::tpic_post_t     u_data_reg;
    tpic_pkg::tpic_post_t     u_data_next;
    logic [tpic_pkg::ROOT_W-1:0] root_inc;
    logic [tpic_pkg::ROOT_W-1:0] root_dec;
    logic                     p_valid_reg;
    tpic_pkg::tpic_prod_t     p_data_reg;
    tpic_pkg::tpic_prod_t     p_data_next;
    logic [tpic_pkg::IDX_W-1:0] tri_val;
    logic [tpic_pkg::IDX_W-1:0] low_diff;
    tpic_pkg::tpic_res_t      res;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    tpic_pkg::tpic_res_t      m_data_reg;
    tpic_pkg::tpic_res_t      m_data_next;
    logic                     skid_valid_reg;
    logic                     skid_valid_next;
    tpic_pkg::tpic_res_t      skid_data_reg;
    logic                     arrive;
    logic                     m_free;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // capture: screen operands, form 8n-7 for the root
    always_comb begin
        s0_data_next      = '0;
        s0_data_next.op   = tpic_pkg::tpic_op_t'(s_opcode);
        s0_data_next.st   = tpic_pkg::ST_OK;
        if (s_opcode == tpic_pkg::OP_ENCODE) begin
            if (s_lower_ordinal[tpic_pkg::IN_ORD_W-1] || s_upper_ordinal[tpic_pkg::IN_ORD_W-1]) begin
                s0_data_next.st = tpic_pkg::ST_NEG;
            end else if (s_lower_ordinal >= s_upper_ordinal) begin
                s0_data_next.st = tpic_pkg::ST_ORDER;
            end else if (tpic_pkg::IN_IDX_W'($unsigned(s_upper_ordinal)) > tpic_pkg::ORD_MAX) begin
                s0_data_next.st = tpic_pkg::ST_RANGE;
            end
            s0_data_next.arg = tpic_pkg::IDX_W'($unsigned(s_lower_ordinal));
            s0_data_next.upe = s_upper_ordinal[tpic_pkg::ORD_BITS-1:0];
        end else begin
            if (s_pair_index[tpic_pkg::IN_IDX_W-1]) begin
                s0_data_next.st = tpic_pkg::ST_NEG;
            end else if (s_pair_index == '0 ||
                         $unsigned(s_pair_index) > tpic_pkg::TRI_MAX) begin
                s0_data_next.st = tpic_pkg::ST_RANGE;
            end
            s0_data_next.arg = s_pair_index[tpic_pkg::IDX_W-1:0];
            s0_data_next.rad = {s_pair_index[tpic_pkg::IDX_W-1:0], 3'b000} - tpic_pkg::RAD_BIAS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_data_reg <= s0_data_next;
        end
    end

    assign root_valid[0] = s0_valid_reg;
    assign root_data[0]  = s0_data_reg;

    for (genvar k = 0; k < tpic_pkg::ROOT_W; k++) begin : g_root
        tpic_root_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (root_valid[k]),
            .in_data   (root_data[k]),
            .out_valid (root_valid[k+1]),
            .out_data  (root_data[k+1])
        );
    end

    // root fixup: for a decode, upper = (r+1)/2, upper-1 = (r-1)/2; an encode passes its upper ordinal through
    always_comb begin
        root_inc        = root_data[tpic_pkg::ROOT_W].root + tpic_pkg::ROOT_W'(1);
        root_dec        = root_data[tpic_pkg::ROOT_W].root - tpic_pkg::ROOT_W'(1);
        u_data_next.op  = root_data[tpic_pkg::ROOT_W].op;
        u_data_next.st  = root_data[tpic_pkg::ROOT_W].st;
        u_data_next.arg = root_data[tpic_pkg::ROOT_W].arg;
        if (root_data[tpic_pkg::ROOT_W].op == tpic_pkg::OP_ENCODE) begin
            u_data_next.u   = root_data[tpic_pkg::ROOT_W].upe;
            u_data_next.um1 = root_data[tpic_pkg::ROOT_W].upe - tpic_pkg::ORD_BITS'(1);
        end else begin
            u_data_next.u   = root_inc[tpic_pkg::ROOT_W-1:1];
            u_data_next.um1 = root_dec[tpic_pkg::ROOT_W-1:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_valid_reg <= 1'b0;
        end else if (en) begin
            u_valid_reg <= root_valid[tpic_pkg::ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_data_reg <= u_data_next;
        end
    end

    always_comb begin
        p_data_next.op   = u_data_reg.op;
        p_data_next.st   = u_data_reg.st;
        p_data_next.arg  = u_data_reg.arg;
        p_data_next.u    = u_data_reg.u;
        p_data_next.prod = tpic_pkg::PROD_W'(u_data_reg.u) * tpic_pkg::PROD_W'(u_data_reg.um1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= u_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_data_reg <= p_data_next;
        end
    end

    always_comb begin
        tri_val    = p_data_reg.prod[tpic_pkg::PROD_W-1:1];
        low_diff   = p_data_reg.arg - tpic_pkg::IDX_W'(1) - tri_val;
        res        = '0;
        res.status = p_data_reg.st;
        if (p_data_reg.st == tpic_pkg::ST_OK) begin
            if (p_data_reg.op == tpic_pkg::OP_ENCODE) begin
                res.index = tri_val + p_data_reg.arg + tpic_pkg::IDX_W'(1);
            end else begin
                res.lower = low_diff[tpic_pkg::ORD_BITS-1:0];
                res.upper = p_data_reg.u;
            end
        end
    end

    // output register with one-beat skid
    assign arrive = en && p_valid_reg;
    assign m_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        if (m_free) begin
            m_valid_next = skid_valid_reg || arrive;
            if (skid_valid_reg) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_data_next = res;
            end
        end else if (arrive) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!m_free && arrive) begin
            skid_data_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_index_out = m_data_reg.index;
    assign m_lower_out = m_data_reg.lower;
    assign m_upper_out = m_data_reg.upper;
    assign m_status    = m_data_reg.status;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid buffer holds a beat while output register is empty");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("skid beat dropped while receiver stalls");

    a_error_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != tpic_pkg::ST_OK) |->
        (m_data_reg.index == '0 && m_data_reg.lower == '0 && m_data_reg.upper == '0))
        else $error("error result carries nonzero payload");

    a_decode_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.upper != '0) |->
        (m_data_reg.lower < m_data_reg.upper && m_data_reg.index == '0 &&
         m_data_reg.status == tpic_pkg::ST_OK))
        else $error("decoded pair not strictly ordered");

endmodule

>>> verif/tpic_codec_checker.sv
// ----------------------------------------------------------------------------
// tpic_codec_checker
// Watches both channels of the triangular pair index codec, computes the
// pair or index that each input beat should produce and compares every result
// beat against the oldest outstanding conversion, field by field.
// ----------------------------------------------------------------------------
module tpic_codec_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic [tpic_pkg::IN_IDX_W-1:0]         s_pair_index,
    input  logic signed [tpic_pkg::IN_ORD_W-1:0]  s_lower_ordinal,
    input  logic signed [tpic_pkg::IN_ORD_W-1:0]  s_upper_ordinal,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [tpic_pkg::IDX_W-1:0]            m_index_out,
    input  logic [tpic_pkg::ORD_BITS-1:0]         m_lower_out,
    input  logic [tpic_pkg::ORD_BITS-1:0]         m_upper_out,
    input  logic [1:0]                            m_status,
    output int                                    mismatches,
    output int                                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ORD_LIMIT = (64'd1 << tpic_pkg::ORD_BITS) - 64'd1;
    localparam longint unsigned TRI_LIMIT = (ORD_LIMIT * (ORD_LIMIT + 64'd1)) / 64'd2;

    tpic_pkg::tpic_res_t conversions_due[$];
    int                  faults  = 0;
    int                  backlog = 0;

    assign mismatches  = faults;
    assign outstanding = backlog;

    function automatic tpic_pkg::tpic_res_t convert_pair_index(
        tpic_pkg::tpic_op_t                   op,
        logic [tpic_pkg::IN_IDX_W-1:0]        idx,
        logic signed [tpic_pkg::IN_ORD_W-1:0] lo,
        logic signed [tpic_pkg::IN_ORD_W-1:0] up);
        tpic_pkg::tpic_res_t r;
        longint unsigned     n;
        longint unsigned     a;
        longint unsigned     b;
        longint unsigned     mid;
        r        = '0;
        r.status = tpic_pkg::ST_OK;
        if (op == tpic_pkg::OP_ENCODE) begin
            if (lo < 0 || up < 0) begin
                r.status = tpic_pkg::ST_NEG;
            end else if (lo >= up) begin
                r.status = tpic_pkg::ST_ORDER;
            end else if (longint'(up) > ORD_LIMIT) begin
                r.status = tpic_pkg::ST_RANGE;
            end else begin
                a       = longint'(up);
                r.index = tpic_pkg::IDX_W'((a * (a - 64'd1)) / 64'd2 + longint'(lo) + 64'd1);
            end
        end else begin
            n = idx;
            if (n[63]) begin
                r.status = tpic_pkg::ST_NEG;
            end else if (n == 0 || n > TRI_LIMIT) begin
                r.status = tpic_pkg::ST_RANGE;
            end else begin
                a = 64'd1;
                b = ORD_LIMIT;
                while (a < b) begin
                    mid = a + (b - a) / 64'd2;
                    if ((mid * (mid + 64'd1)) / 64'd2 >= n) begin
                        b = mid;
                    end else begin
                        a = mid + 64'd1;
                    end
                end
                r.upper = tpic_pkg::ORD_BITS'(a);
                r.lower = tpic_pkg::ORD_BITS'(n - 64'd1 - (a * (a - 64'd1)) / 64'd2);
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        tpic_pkg::tpic_res_t due;
        if (!aresetn) begin
            conversions_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                conversions_due.push_back(convert_pair_index(tpic_pkg::tpic_op_t'(s_opcode),
                                                             s_pair_index, s_lower_ordinal,
                                                             s_upper_ordinal));
            end
            if (m_valid && m_ready) begin
                if (conversions_due.size() == 0) begin
                    $error("result beat with no conversion outstanding");
                    faults++;
                end else begin
                    due = conversions_due.pop_front();
                    if (m_index_out !== due.index) begin
                        $error("index_out: expected %0d, actual %0d", due.index, m_index_out);
                        faults++;
                    end
                    if (m_lower_out !== due.lower) begin
                        $error("lower_out: expected %0d, actual %0d", due.lower, m_lower_out);
                        faults++;
                    end
                    if (m_upper_out !== due.upper) begin
                        $error("upper_out: expected %0d, actual %0d", due.upper, m_upper_out);
                        faults++;
                    end
                    if (m_status !== due.status) begin
                        $error("status: expected %0d, actual %0d", due.status, m_status);
                        faults++;
                    end
                end
            end
        end
        backlog <= conversions_due.size();
    end

endmodule

>>> verif/tb_triangular_pair_index_codec_unit.sv
// ----------------------------------------------------------------------------
// tb_triangular_pair_index_codec_unit
// Drives encode and decode beats into the codec: a directed set of range
// edges and error cases, then random well-formed pairs and indices mixed with
// raw noise, under random gaps, random output stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_triangular_pair_index_codec_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int             CYCLE_LIMIT = 200000;
    localparam int             DRAIN       = 50;
    localparam int             HOLD_BEAT   = 500;
    localparam int             HOLD_CYCLES = 300;
    localparam logic [31:0]    ORD_TOP     = 32'(tpic_pkg::ORD_MAX);
    localparam logic [31:0]    ORD_MIN     = 32'h8000_0000;
    localparam logic [63:0]    IDX_TOP     = 64'(tpic_pkg::TRI_MAX);

    logic                                 aclk            = 1'b0;
    logic                                 aresetn         = 1'b0;
    logic                                 s_valid         = 1'b0;
    logic                                 s_ready;
    logic                                 s_opcode        = 1'b0;
    logic signed [tpic_pkg::IN_IDX_W-1:0] s_pair_index    = '0;
    logic signed [tpic_pkg::IN_ORD_W-1:0] s_lower_ordinal = '0;
    logic signed [tpic_pkg::IN_ORD_W-1:0] s_upper_ordinal = '0;
    logic                                 m_valid;
    logic                                 m_ready         = 1'b0;
    logic [tpic_pkg::IDX_W-1:0]           m_index_out;
    logic [tpic_pkg::ORD_BITS-1:0]        m_lower_out;
    logic [tpic_pkg::ORD_BITS-1:0]        m_upper_out;
    logic [1:0]                           m_status;

    int  mismatches;
    int  outstanding;
    int  cycles = 0;
    bit  steady = 1'b0;

    triangular_pair_index_codec_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pair_index    (s_pair_index),
        .s_lower_ordinal (s_lower_ordinal),
        .s_upper_ordinal (s_upper_ordinal),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_index_out     (m_index_out),
        .m_lower_out     (m_lower_out),
        .m_upper_out     (m_upper_out),
        .m_status        (m_status)
    );

    tpic_codec_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pair_index    (s_pair_index),
        .s_lower_ordinal (s_lower_ordinal),
        .s_upper_ordinal (s_upper_ordinal),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_index_out     (m_index_out),
        .m_lower_out     (m_lower_out),
        .m_upper_out     (m_upper_out),
        .m_status        (m_status),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] random_upper();
        logic [31:0] u;
        u = $urandom >> $urandom_range(1, 31);
        return (u == 0) ? 32'd1 : u;
    endfunction

    task automatic offer_conversion(tpic_pkg::tpic_op_t op, logic [63:0] idx, logic [31:0] lo,
                                   logic [31:0] up);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_pair_index    <= idx;
        s_lower_ordinal <= lo;
        s_upper_ordinal <= up;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer_decode(logic [63:0] idx);
        offer_conversion(tpic_pkg::OP_DECODE, idx, $urandom, $urandom);
    endtask

    task automatic offer_encode(logic [31:0] lo, logic [31:0] up);
        offer_conversion(tpic_pkg::OP_ENCODE, {$urandom, $urandom}, lo, up);
    endtask

    // result side: random stalls, one long hold-off while input keeps coming
    initial begin
        int beats;
        int stall;
        beats = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (beats == HOLD_BEAT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = steady ? 0 : $urandom_range(0, 10);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats++;
        end
    end

    initial begin
        longint unsigned u;
        longint unsigned lo;
        logic [31:0]     eu;
        int              kind;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_decode(64'd0);
        offer_decode(64'd1);
        offer_decode(64'd2);
        offer_decode(64'd3);
        offer_decode(64'd4);
        offer_decode(64'h8000_0000_0000_0000);
        offer_decode(64'hFFFF_FFFF_FFFF_FFFF);
        offer_decode(64'h7FFF_FFFF_FFFF_FFFF);
        offer_decode(IDX_TOP);
        offer_decode(IDX_TOP + 64'd1);
        offer_decode(IDX_TOP - 64'(ORD_TOP) + 64'd1);
        offer_decode(IDX_TOP - 64'(ORD_TOP));
        offer_encode(32'd0, 32'd1);
        offer_encode(32'd0, 32'd0);
        offer_encode(32'd3, 32'd3);
        offer_encode(32'd5, 32'd3);
        offer_encode(32'hFFFF_FFFF, 32'd5);
        offer_encode(32'd5, 32'hFFFF_FFFF);
        offer_encode(ORD_MIN, ORD_MIN);
        offer_encode(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        offer_encode(ORD_TOP - 32'd1, ORD_TOP);
        offer_encode(32'd0, ORD_TOP);
        offer_encode(ORD_TOP, ORD_TOP);
        offer_encode(ORD_TOP, 32'd0);
        offer_encode(32'd0, ORD_MIN);

        for (int i = 0; i < 1000; i++) begin
            steady = (i >= 300 && i < 420) || (i >= 700 && i < 760);
            kind   = $urandom_range(0, 9);
            case (kind) inside
                [0:3]: begin
                    u  = random_upper();
                    lo = $urandom_range(0, 32'(u - 1));
                    offer_decode((u * (u - 64'd1)) / 64'd2 + lo + 64'd1);
                end
                4: begin
                    u = random_upper();
                    offer_decode((u * (u + 64'd1)) / 64'd2 + 64'($urandom_range(0, 1)));
                end
                [5:7]: begin
                    eu = random_upper();
                    offer_encode($urandom_range(0, eu - 32'd1), eu);
                end
                8: begin
                    offer_encode($urandom, $urandom);
                end
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        offer_decode({$urandom, $urandom} >> $urandom_range(0, 63));
                    end else begin
                        offer_decode(IDX_TOP + 64'($urandom_range(0, 4)) - 64'd2);
                    end
                end
            endcase
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        do @(negedge aclk); while (outstanding != 0);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tpic_pkg.sv
rtl/core/tpic_root_step.sv
rtl/core/triangular_pair_index_codec_unit.sv
verif/tpic_codec_checker.sv
verif/tb_triangular_pair_index_codec_unit.sv
